>>> rtl/c6502_pkg.sv
// shared types, state codes, decode tables and alu helpers for the 6502 core
package c6502_pkg;

   typedef struct packed {
      logic       command;
      logic [7:0] read_data;
   } req_type;

   typedef struct packed {
      logic [15:0] bus_address;
      logic        write_enable;
      logic [7:0]  write_data;
      logic [1:0]  run_status;
      logic [7:0]  flags_out;
      logic        last;
   } rsp_type;

   typedef enum logic [12:0] {
      Q_IDLE    = 13'h0001,
      Q_VEC_LO  = 13'h0002,
      Q_VEC_HI  = 13'h0004,
      Q_FETCH   = 13'h0008,
      Q_OP1     = 13'h0010,
      Q_OP2     = 13'h0020,
      Q_PTR_LO  = 13'h0040,
      Q_PTR_HI  = 13'h0080,
      Q_DATA    = 13'h0100,
      Q_PULL1   = 13'h0200,
      Q_PULL_LO = 13'h0400,
      Q_PULL_HI = 13'h0800,
      Q_STOP    = 13'h1000
   } step_type;

   typedef enum logic [3:0] {
      M_IMP, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABX, M_ABY, M_IZX, M_IZY, M_REL, M_IND
   } mode_type;

   typedef enum logic [4:0] {
      K_ILL, K_HALT, K_ORA, K_AND, K_EOR, K_ADC, K_STA, K_LDA, K_CMP, K_SBC,
      K_ASL, K_ROL, K_LSR, K_ROR, K_STX, K_LDX, K_DEC, K_INC, K_BIT, K_STY,
      K_LDY, K_CPY, K_CPX, K_JMP, K_JSR, K_BRK, K_RTI, K_RTS, K_BR, K_IMPL
   } kind_type;

   typedef struct packed {
      mode_type mode;
      kind_type kind;
   } dec_type;

   // one bus access staged for the output queue
   typedef struct packed {
      logic [15:0] addr;
      logic        we;
      logic [7:0]  wd;
   } acc_type;

   localparam logic [15:0] VEC_RESET  = 16'hFFFC;
   localparam logic [15:0] VEC_BRK    = 16'hFFFE;
   localparam logic [7:0]  STACK_PAGE = 8'h01;
   localparam logic [7:0]  KEEP_FLAGS = 8'hCF;
   localparam logic [7:0]  PUSH_MARK  = 8'h30;
   localparam logic [7:0]  NV_BITS    = 8'hC0;
   localparam logic [7:0]  F_C = 8'h01;
   localparam logic [7:0]  F_Z = 8'h02;
   localparam logic [7:0]  F_I = 8'h04;
   localparam logic [7:0]  F_D = 8'h08;
   localparam logic [7:0]  F_V = 8'h40;
   localparam logic [7:0]  F_N = 8'h80;
   localparam logic [1:0]  RUN_OK = 2'd0;
   localparam logic [1:0]  RUN_HALT = 2'd1;
   localparam logic [1:0]  RUN_ILL = 2'd2;

   localparam logic [7:0] OP_PHP = 8'h08, OP_PHA = 8'h48, OP_PLP = 8'h28, OP_PLA = 8'h68;
   localparam logic [7:0] OP_DEY = 8'h88, OP_TAY = 8'hA8, OP_INY = 8'hC8, OP_INX = 8'hE8;
   localparam logic [7:0] OP_CLC = 8'h18, OP_SEC = 8'h38, OP_CLI = 8'h58, OP_SEI = 8'h78;
   localparam logic [7:0] OP_TYA = 8'h98, OP_CLV = 8'hB8, OP_CLD = 8'hD8, OP_SED = 8'hF8;
   localparam logic [7:0] OP_TXA = 8'h8A, OP_TAX = 8'hAA, OP_DEX = 8'hCA, OP_TXS = 8'h9A;
   localparam logic [7:0] OP_TSX = 8'hBA, OP_RTI = 8'h40, OP_RTS = 8'h60, OP_HLT = 8'h02;
   localparam logic [7:0] OP_LDXI = 8'hA2, OP_STAI = 8'h89;

   function automatic kind_type g0_kind(input logic [2:0] a);
      kind_type k;
      unique case (a)
         3'd1: k = K_BIT;
         3'd4: k = K_STY;
         3'd5: k = K_LDY;
         3'd6: k = K_CPY;
         3'd7: k = K_CPX;
         default: k = K_ILL;
      endcase
      return k;
   endfunction

   function automatic kind_type k_shift(input logic [2:0] a);
      return kind_type'(5'(K_ASL) + {2'b00, a});
   endfunction

   function automatic dec_type decode(input logic [7:0] op);
      dec_type d;
      logic [2:0] a, b;
      logic [1:0] c;
      a = op[7:5];
      b = op[4:2];
      c = op[1:0];
      d.mode = M_IMP;
      d.kind = K_ILL;
      if (c == 2'd1) begin
         if (op != OP_STAI) begin
            unique case (b)
               3'd0: d.mode = M_IZX;
               3'd1: d.mode = M_ZP;
               3'd2: d.mode = M_IMM;
               3'd3: d.mode = M_ABS;
               3'd4: d.mode = M_IZY;
               3'd5: d.mode = M_ZPX;
               3'd6: d.mode = M_ABY;
               default: d.mode = M_ABX;
            endcase
            d.kind = kind_type'(5'(K_ORA) + {2'b00, a});
         end
      end else if (c == 2'd2) begin
         if (op == OP_HLT) begin
            d.kind = K_HALT;
         end else begin
            unique case (b)
               3'd0: if (op == OP_LDXI) begin
                  d.mode = M_IMM;
                  d.kind = K_LDX;
               end
               3'd1: begin
                  d.mode = M_ZP;
                  d.kind = k_shift(a);
               end
               3'd2: d.kind = (a < 3'd4) ? k_shift(a) : K_IMPL;
               3'd3: begin
                  d.mode = M_ABS;
                  d.kind = k_shift(a);
               end
               3'd5: begin
                  d.mode = (a == 3'd4 || a == 3'd5) ? M_ZPY : M_ZPX;
                  d.kind = k_shift(a);
               end
               3'd6: if (op == OP_TXS || op == OP_TSX) d.kind = K_IMPL;
               3'd7: if (a != 3'd4) begin
                  d.mode = (a == 3'd5) ? M_ABY : M_ABX;
                  d.kind = k_shift(a);
               end
               default: ;
            endcase
         end
      end else if (c == 2'd0) begin
         unique case (b)
            3'd0: begin
               if (a == 3'd0) d.kind = K_BRK;
               else if (a == 3'd1) begin
                  d.mode = M_ABS;
                  d.kind = K_JSR;
               end else if (a == 3'd2) d.kind = K_RTI;
               else if (a == 3'd3) d.kind = K_RTS;
               else if (a >= 3'd5) begin
                  d.mode = M_IMM;
                  d.kind = g0_kind(a);
               end
            end
            3'd1: begin
               d.mode = M_ZP;
               d.kind = g0_kind(a);
            end
            3'd2, 3'd6: d.kind = K_IMPL;
            3'd3: begin
               d.mode = M_ABS;
               if (a == 3'd2) d.kind = K_JMP;
               else if (a == 3'd3) begin
                  d.mode = M_IND;
                  d.kind = K_JMP;
               end else d.kind = g0_kind(a);
            end
            3'd4: begin
               d.mode = M_REL;
               d.kind = K_BR;
            end
            3'd5: if (a == 3'd4 || a == 3'd5) begin
               d.mode = M_ZPX;
               d.kind = g0_kind(a);
            end
            default: if (a == 3'd5) begin
               d.mode = M_ABX;
               d.kind = K_LDY;
            end
         endcase
      end
      return d;
   endfunction

   function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
      logic [7:0] r;
      r = p;
      r[7] = v[7];
      r[1] = (v == 8'h00);
      return r;
   endfunction

endpackage

>>> rtl/cpu_6502_instruction_core_unit.sv
// top level of the bus-level 6502 instruction core
//  channel  direction  handshake              payload
//  req      in         req_valid/req_ready    c6502_pkg::req_type (command, read_data)
//  rsp      out        rsp_valid/rsp_ready    c6502_pkg::rsp_type (one bus access)
// a request transaction is executed in the cycle it is accepted and its accesses are
// loaded into a four entry result queue; one access leaves per cycle while rsp_ready is
// high, and a new request is taken only once the queue is empty or hands out its last.
// req_ready is high when the queue is empty or drains its last entry this cycle.
// synchronous reset clears all architectural state and the queue; the core then waits for start.
module cpu_6502_instruction_core_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  c6502_pkg::req_type    req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output c6502_pkg::rsp_type    rsp_payload
);

   c6502_pkg::acc_type acc_list [4];
   logic [2:0] acc_count;
   logic [1:0] stat;
   logic [7:0] flags;
   logic       go;
   logic       empty_next;

   assign req_ready = empty_next;
   assign go = req_valid && req_ready;

   c6502_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .req       (req_payload),
      .acc_list  (acc_list),
      .acc_count (acc_count),
      .stat      (stat),
      .flags     (flags)
   );

   c6502_outq u_outq (
      .clock       (clock),
      .reset       (reset),
      .load        (go),
      .acc_list    (acc_list),
      .acc_count   (acc_count),
      .stat        (stat),
      .flags       (flags),
      .empty_next  (empty_next),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> rtl/c6502_alu.sv
// operand alu: logic, binary and decimal add and subtract, loads, compares, bit, shifts, inc and dec
module c6502_alu (
   input  c6502_pkg::kind_type kind,
   input  logic [7:0]          v,
   input  logic [7:0]          acc,
   input  logic [7:0]          xr,
   input  logic [7:0]          yr,
   input  logic [7:0]          p,
   output logic [7:0]          acc_out,
   output logic [7:0]          x_out,
   output logic [7:0]          y_out,
   output logic [7:0]          p_out,
   output logic                wb,
   output logic [7:0]          wb_data
);

   logic       cin;
   logic [8:0] bin;
   logic [7:0] nv;
   logic [4:0] lo;
   logic [9:0] s;
   logic signed [6:0] slo;
   logic signed [10:0] sr;
   logic [8:0] cmpd;
   logic [7:0] cmpr;
   logic [7:0] r;

   always_comb begin
      cin = p[0];
      acc_out = acc;
      x_out = xr;
      y_out = yr;
      p_out = p;
      wb = 1'b0;
      wb_data = 8'h00;
      bin = 9'd0;
      nv = ~v;
      lo = 5'd0;
      s = 10'd0;
      slo = 7'sd0;
      sr = 11'sd0;
      cmpd = 9'd0;
      cmpr = acc;
      r = 8'h00;
      unique case (kind)
         c6502_pkg::K_ORA: begin
            acc_out = acc | v;
            p_out = c6502_pkg::set_nz(p, acc | v);
         end
         c6502_pkg::K_AND: begin
            acc_out = acc & v;
            p_out = c6502_pkg::set_nz(p, acc & v);
         end
         c6502_pkg::K_EOR: begin
            acc_out = acc ^ v;
            p_out = c6502_pkg::set_nz(p, acc ^ v);
         end
         c6502_pkg::K_ADC: begin
            bin = {1'b0, acc} + {1'b0, v} + {8'd0, cin};
            if (p[3]) begin
               lo = {1'b0, acc[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
               if (lo >= 5'd10) lo = {1'b0, 4'(lo[3:0] + 4'd6)} + 5'h10;
               s = {2'b00, acc[7:4], 4'h0} + {2'b00, v[7:4], 4'h0} + {5'd0, lo};
               p_out[6] = ~(acc[7] ^ v[7]) & (acc[7] ^ s[7]);
               p_out[7] = s[7];
               p_out[1] = (bin[7:0] == 8'h00);
               if (s >= 10'h0A0) s = s + 10'h060;
               p_out[0] = (s >= 10'h100);
               acc_out = s[7:0];
            end else begin
               p_out[6] = ~(acc[7] ^ v[7]) & (acc[7] ^ bin[7]);
               p_out[0] = bin[8];
               p_out = c6502_pkg::set_nz(p_out, bin[7:0]);
               acc_out = bin[7:0];
            end
         end
         c6502_pkg::K_SBC: begin
            bin = {1'b0, acc} + {1'b0, nv} + {8'd0, cin};
            p_out[6] = ~(acc[7] ^ nv[7]) & (acc[7] ^ bin[7]);
            p_out[0] = bin[8];
            p_out = c6502_pkg::set_nz(p_out, bin[7:0]);
            if (p[3]) begin
               slo = $signed({3'b000, acc[3:0]}) - $signed({3'b000, v[3:0]})
                     + $signed({6'd0, cin}) - 7'sd1;
               if (slo < 0) slo = $signed({3'b000, 4'(slo[3:0] + 4'd10)}) - 7'sd16;
               sr = $signed({3'b000, acc[7:4], 4'h0}) - $signed({3'b000, v[7:4], 4'h0})
                    + 11'(slo);
               if (sr < 0) sr = sr - 11'sd96;
               acc_out = sr[7:0];
            end else begin
               acc_out = bin[7:0];
            end
         end
         c6502_pkg::K_LDA: begin
            acc_out = v;
            p_out = c6502_pkg::set_nz(p, v);
         end
         c6502_pkg::K_LDX: begin
            x_out = v;
            p_out = c6502_pkg::set_nz(p, v);
         end
         c6502_pkg::K_LDY: begin
            y_out = v;
            p_out = c6502_pkg::set_nz(p, v);
         end
         c6502_pkg::K_CMP, c6502_pkg::K_CPX, c6502_pkg::K_CPY: begin
            cmpr = (kind == c6502_pkg::K_CPX) ? xr : (kind == c6502_pkg::K_CPY) ? yr : acc;
            cmpd = {1'b0, cmpr} - {1'b0, v};
            p_out[0] = ~cmpd[8];
            p_out = c6502_pkg::set_nz(p_out, cmpd[7:0]);
         end
         c6502_pkg::K_BIT: begin
            p_out = (p & ~c6502_pkg::NV_BITS) | (v & c6502_pkg::NV_BITS);
            p_out[1] = ((acc & v) == 8'h00);
         end
         c6502_pkg::K_ASL, c6502_pkg::K_ROL, c6502_pkg::K_LSR, c6502_pkg::K_ROR,
         c6502_pkg::K_DEC, c6502_pkg::K_INC: begin
            unique case (kind)
               c6502_pkg::K_ASL: begin
                  r = {v[6:0], 1'b0};
                  p_out[0] = v[7];
               end
               c6502_pkg::K_ROL: begin
                  r = {v[6:0], cin};
                  p_out[0] = v[7];
               end
               c6502_pkg::K_LSR: begin
                  r = {1'b0, v[7:1]};
                  p_out[0] = v[0];
               end
               c6502_pkg::K_ROR: begin
                  r = {cin, v[7:1]};
                  p_out[0] = v[0];
               end
               c6502_pkg::K_DEC: r = v - 8'd1;
               default: r = v + 8'd1;
            endcase
            p_out = c6502_pkg::set_nz(p_out, r);
            wb = 1'b1;
            wb_data = r;
         end
         default: ;
      endcase
   end

endmodule

>>> rtl/c6502_seq.sv
// instruction sequencer: register file, step state and bus access generation per transaction
module c6502_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  c6502_pkg::req_type    req,
   output c6502_pkg::acc_type    acc_list [4],
   output logic [2:0]            acc_count,
   output logic [1:0]            stat,
   output logic [7:0]            flags
);

   logic [15:0] pc_ff, pc_in;
   logic [7:0]  a_ff, a_in, x_ff, x_in, y_ff, y_in, sp_ff, sp_in, p_ff, p_in, op_ff, op_in;
   c6502_pkg::step_type step_ff, step_in;
   logic [15:0] ow_ff, ow_in, ea_ff, ea_in;
   logic [1:0]  stop_ff, stop_in;

   c6502_pkg::dec_type dcur, dnew, dsel;
   logic [7:0] alu_v, alu_a, alu_x, alu_y, alu_p, alu_wbd;
   logic       alu_wb;
   logic [7:0] d;
   logic [15:0] w, v16, pc1, ret;
   logic       have, want, isst;
   logic [7:0] stv;

   assign dcur = c6502_pkg::decode(op_ff);
   assign dnew = c6502_pkg::decode(req.read_data);
   assign d = req.read_data;
   assign dsel = (step_ff == c6502_pkg::Q_FETCH) ? dnew : dcur;

   c6502_alu u_alu (
      .kind    (dsel.kind),
      .v       (alu_v),
      .acc     (a_ff),
      .xr      (x_ff),
      .yr      (y_ff),
      .p       (p_ff),
      .acc_out (alu_a),
      .x_out   (alu_x),
      .y_out   (alu_y),
      .p_out   (alu_p),
      .wb      (alu_wb),
      .wb_data (alu_wbd)
   );

   always_comb begin
      alu_v = d;
      if (step_ff == c6502_pkg::Q_FETCH) alu_v = a_ff;
   end

   always_comb begin
      pc_in = pc_ff;
      a_in = a_ff;
      x_in = x_ff;
      y_in = y_ff;
      sp_in = sp_ff;
      p_in = p_ff;
      op_in = op_ff;
      step_in = step_ff;
      ow_in = ow_ff;
      ea_in = ea_ff;
      stop_in = stop_ff;
      acc_count = 3'd0;
      for (int i = 0; i < 4; i++) acc_list[i] = '0;
      w = {d, ow_ff[7:0]};
      v16 = 16'h0000;
      pc1 = pc_ff + 16'd1;
      ret = 16'h0000;
      have = 1'b0;
      want = 1'b0;
      isst = 1'b0;
      stv = 8'h00;
      if (!req.command) begin
         sp_in = 8'hFF;
         p_in = p_ff | c6502_pkg::F_I;
         stop_in = c6502_pkg::RUN_OK;
         ea_in = c6502_pkg::VEC_RESET;
         step_in = c6502_pkg::Q_VEC_LO;
         acc_list[0] = '{addr: c6502_pkg::VEC_RESET, we: 1'b0, wd: 8'h00};
         acc_count = 3'd1;
      end else begin
         unique case (step_ff)
            c6502_pkg::Q_VEC_LO: begin
               ow_in = {8'h00, d};
               step_in = c6502_pkg::Q_VEC_HI;
               acc_list[0] = '{addr: ea_ff + 16'd1, we: 1'b0, wd: 8'h00};
               acc_count = 3'd1;
            end
            c6502_pkg::Q_VEC_HI: begin
               pc_in = w;
               step_in = c6502_pkg::Q_FETCH;
               acc_list[0] = '{addr: w, we: 1'b0, wd: 8'h00};
               acc_count = 3'd1;
            end
            c6502_pkg::Q_FETCH: begin
               op_in = d;
               if (dnew.kind == c6502_pkg::K_HALT || dnew.kind == c6502_pkg::K_ILL) begin
                  stop_in = (dnew.kind == c6502_pkg::K_HALT) ? c6502_pkg::RUN_HALT
                                                             : c6502_pkg::RUN_ILL;
                  step_in = c6502_pkg::Q_STOP;
                  acc_list[0] = '{addr: pc_ff, we: 1'b0, wd: 8'h00};
                  acc_count = 3'd1;
               end else if (dnew.mode != c6502_pkg::M_IMP) begin
                  pc_in = pc1;
                  step_in = c6502_pkg::Q_OP1;
                  acc_list[0] = '{addr: pc1, we: 1'b0, wd: 8'h00};
                  acc_count = 3'd1;
               end else begin
                  pc_in = pc1;
                  step_in = c6502_pkg::Q_FETCH;
                  acc_list[0] = '{addr: pc1, we: 1'b0, wd: 8'h00};
                  acc_count = 3'd1;
                  if (dnew.kind == c6502_pkg::K_ASL || dnew.kind == c6502_pkg::K_ROL ||
                      dnew.kind == c6502_pkg::K_LSR || dnew.kind == c6502_pkg::K_ROR) begin
                     a_in = alu_wbd;
                     p_in = alu_p;
                  end else if (dnew.kind == c6502_pkg::K_BRK) begin
                     ret = pc_ff + 16'd2;
                     pc_in = ret;
                     acc_list[0] = '{addr: {c6502_pkg::STACK_PAGE, sp_ff}, we: 1'b1,
                                     wd: ret[15:8]};
                     acc_list[1] = '{addr: {c6502_pkg::STACK_PAGE, 8'(sp_ff - 8'd1)},
                                     we: 1'b1, wd: ret[7:0]};
                     acc_list[2] = '{addr: {c6502_pkg::STACK_PAGE, 8'(sp_ff - 8'd2)},
                                     we: 1'b1, wd: p_ff | c6502_pkg::PUSH_MARK};
                     acc_list[3] = '{addr: c6502_pkg::VEC_BRK, we: 1'b0, wd: 8'h00};
                     acc_count = 3'd4;
                     sp_in = sp_ff - 8'd3;
                     p_in = p_ff | c6502_pkg::F_I;
                     ea_in = c6502_pkg::VEC_BRK;
                     step_in = c6502_pkg::Q_VEC_LO;
                  end else if (dnew.kind == c6502_pkg::K_RTI || dnew.kind == c6502_pkg::K_RTS
                               || d == c6502_pkg::OP_PLP || d == c6502_pkg::OP_PLA) begin
                     sp_in = sp_ff + 8'd1;
                     step_in = (dnew.kind == c6502_pkg::K_RTS) ? c6502_pkg::Q_PULL_LO
                                                               : c6502_pkg::Q_PULL1;
                     acc_list[0] = '{addr: {c6502_pkg::STACK_PAGE, 8'(sp_ff + 8'd1)},
                                     we: 1'b0, wd: 8'h00};
                  end else if (d == c6502_pkg::OP_PHP || d == c6502_pkg::OP_PHA) begin
                     acc_list[0] = '{addr: {c6502_pkg::STACK_PAGE, sp_ff}, we: 1'b1,
                                     wd: (d == c6502_pkg::OP_PHP) ?
                                         (p_ff | c6502_pkg::PUSH_MARK) : a_ff};
                     acc_list[1] = '{addr: pc1, we: 1'b0, wd: 8'h00};
                     acc_count = 3'd2;
                     sp_in = sp_ff - 8'd1;
                  end else begin
                     priority case (d)
                        c6502_pkg::OP_DEY: begin
                           y_in = y_ff - 8'd1;
                           p_in = c6502_pkg::set_nz(p_ff, 8'(y_ff - 8'd1));
                        end
                        c6502_pkg::OP_TAY: begin
                           y_in = a_ff;
                           p_in = c6502_pkg::set_nz(p_ff, a_ff);
                        end
                        c6502_pkg::OP_INY: begin
                           y_in = y_ff + 8'd1;
                           p_in = c6502_pkg::set_nz(p_ff, 8'(y_ff + 8'd1));
                        end
                        c6502_pkg::OP_INX: begin
                           x_in = x_ff + 8'd1;
                           p_in = c6502_pkg::set_nz(p_ff, 8'(x_ff + 8'd1));
                        end
                        c6502_pkg::OP_CLC: p_in = p_ff & ~c6502_pkg::F_C;
                        c6502_pkg::OP_SEC: p_in = p_ff | c6502_pkg::F_C;
                        c6502_pkg::OP_CLI: p_in = p_ff & ~c6502_pkg::F_I;
                        c6502_pkg::OP_SEI: p_in = p_ff | c6502_pkg::F_I;
                        c6502_pkg::OP_TYA: begin
                           a_in = y_ff;
                           p_in = c6502_pkg::set_nz(p_ff, y_ff);
                        end
                        c6502_pkg::OP_CLV: p_in = p_ff & ~c6502_pkg::F_V;
                        c6502_pkg::OP_CLD: p_in = p_ff & ~c6502_pkg::F_D;
                        c6502_pkg::OP_SED: p_in = p_ff | c6502_pkg::F_D;
                        c6502_pkg::OP_TXA: begin
                           a_in = x_ff;
                           p_in = c6502_pkg::set_nz(p_ff, x_ff);
                        end
                        c6502_pkg::OP_TAX: begin
                           x_in = a_ff;
                           p_in = c6502_pkg::set_nz(p_ff, a_ff);
                        end
                        c6502_pkg::OP_DEX: begin
                           x_in = x_ff - 8'd1;
                           p_in = c6502_pkg::set_nz(p_ff, 8'(x_ff - 8'd1));
                        end
                        c6502_pkg::OP_TXS: sp_in = x_ff;
                        c6502_pkg::OP_TSX: begin
                           x_in = sp_ff;
                           p_in = c6502_pkg::set_nz(p_ff, sp_ff);
                        end
                        default: ;
                     endcase
                  end
               end
            end
            c6502_pkg::Q_OP1: begin
               ow_in = {8'h00, d};
               pc_in = pc1;
               step_in = c6502_pkg::Q_FETCH;
               acc_list[0] = '{addr: pc1, we: 1'b0, wd: 8'h00};
               acc_count = 3'd1;
               unique case (dcur.mode)
                  c6502_pkg::M_IMM: begin
                     a_in = alu_a;
                     x_in = alu_x;
                     y_in = alu_y;
                     p_in = alu_p;
                  end
                  c6502_pkg::M_REL: begin
                     unique case (op_ff[7:6])
                        2'd0: have = p_ff[7];
                        2'd1: have = p_ff[6];
                        2'd2: have = p_ff[0];
                        default: have = p_ff[1];
                     endcase
                     want = op_ff[5];
                     if (have == want) begin
                        pc_in = pc1 + {{8{d[7]}}, d};
                        acc_list[0].addr = pc_in;
                     end
                  end
                  c6502_pkg::M_ZP, c6502_pkg::M_ZPX, c6502_pkg::M_ZPY: begin
                     if (dcur.mode == c6502_pkg::M_ZP) ea_in = {8'h00, d};
                     else if (dcur.mode == c6502_pkg::M_ZPX) ea_in = {8'h00, 8'(d + x_ff)};
                     else ea_in = {8'h00, 8'(d + y_ff)};
                     isst = 1'b1;
                  end
                  c6502_pkg::M_IZX, c6502_pkg::M_IZY: begin
                     ea_in = (dcur.mode == c6502_pkg::M_IZX) ? {8'h00, 8'(d + x_ff)}
                                                             : {8'h00, d};
                     step_in = c6502_pkg::Q_PTR_LO;
                     acc_list[0].addr = ea_in;
                  end
                  default: begin
                     step_in = c6502_pkg::Q_OP2;
                  end
               endcase
            end
            c6502_pkg::Q_OP2: begin
               ow_in = w;
               pc_in = pc1;
               step_in = c6502_pkg::Q_FETCH;
               acc_list[0] = '{addr: w, we: 1'b0, wd: 8'h00};
               acc_count = 3'd1;
               if (dcur.kind == c6502_pkg::K_JMP && dcur.mode == c6502_pkg::M_IND) begin
                  ea_in = w;
                  step_in = c6502_pkg::Q_PTR_LO;
               end else if (dcur.kind == c6502_pkg::K_JMP) begin
                  pc_in = w;
               end else if (dcur.kind == c6502_pkg::K_JSR) begin
                  acc_list[0] = '{addr: {c6502_pkg::STACK_PAGE, sp_ff}, we: 1'b1,
                                  wd: pc_ff[15:8]};
                  acc_list[1] = '{addr: {c6502_pkg::STACK_PAGE, 8'(sp_ff - 8'd1)},
                                  we: 1'b1, wd: pc_ff[7:0]};
                  acc_list[2] = '{addr: w, we: 1'b0, wd: 8'h00};
                  acc_count = 3'd3;
                  sp_in = sp_ff - 8'd2;
                  pc_in = w;
               end else begin
                  if (dcur.mode == c6502_pkg::M_ABX) ea_in = w + {8'h00, x_ff};
                  else if (dcur.mode == c6502_pkg::M_ABY) ea_in = w + {8'h00, y_ff};
                  else ea_in = w;
                  isst = 1'b1;
               end
            end
            c6502_pkg::Q_PTR_LO: begin
               ow_in = {8'h00, d};
               if (dcur.mode == c6502_pkg::M_IND) v16 = {ea_ff[15:8], 8'(ea_ff[7:0] + 8'd1)};
               else v16 = {8'h00, 8'(ea_ff[7:0] + 8'd1)};
               step_in = c6502_pkg::Q_PTR_HI;
               acc_list[0] = '{addr: v16, we: 1'b0, wd: 8'h00};
               acc_count = 3'd1;
            end
            c6502_pkg::Q_PTR_HI: begin
               acc_count = 3'd1;
               if (dcur.mode == c6502_pkg::M_IND) begin
                  pc_in = w;
                  step_in = c6502_pkg::Q_FETCH;
                  acc_list[0] = '{addr: w, we: 1'b0, wd: 8'h00};
               end else begin
                  ea_in = (dcur.mode == c6502_pkg::M_IZY) ? (w + {8'h00, y_ff}) : w;
                  isst = 1'b1;
               end
            end
            c6502_pkg::Q_DATA: begin
               a_in = alu_a;
               x_in = alu_x;
               y_in = alu_y;
               p_in = alu_p;
               step_in = c6502_pkg::Q_FETCH;
               if (alu_wb) begin
                  acc_list[0] = '{addr: ea_ff, we: 1'b1, wd: alu_wbd};
                  acc_list[1] = '{addr: pc_ff, we: 1'b0, wd: 8'h00};
                  acc_count = 3'd2;
               end else begin
                  acc_list[0] = '{addr: pc_ff, we: 1'b0, wd: 8'h00};
                  acc_count = 3'd1;
               end
            end
            c6502_pkg::Q_PULL1: begin
               step_in = c6502_pkg::Q_FETCH;
               acc_list[0] = '{addr: pc_ff, we: 1'b0, wd: 8'h00};
               acc_count = 3'd1;
               if (op_ff == c6502_pkg::OP_PLA) begin
                  a_in = d;
                  p_in = c6502_pkg::set_nz(p_ff, d);
               end else begin
                  p_in = d & c6502_pkg::KEEP_FLAGS;
                  if (op_ff == c6502_pkg::OP_RTI) begin
                     sp_in = sp_ff + 8'd1;
                     step_in = c6502_pkg::Q_PULL_LO;
                     acc_list[0].addr = {c6502_pkg::STACK_PAGE, 8'(sp_ff + 8'd1)};
                  end
               end
            end
            c6502_pkg::Q_PULL_LO: begin
               ow_in = {8'h00, d};
               sp_in = sp_ff + 8'd1;
               step_in = c6502_pkg::Q_PULL_HI;
               acc_list[0] = '{addr: {c6502_pkg::STACK_PAGE, 8'(sp_ff + 8'd1)}, we: 1'b0,
                               wd: 8'h00};
               acc_count = 3'd1;
            end
            c6502_pkg::Q_PULL_HI: begin
               pc_in = (op_ff == c6502_pkg::OP_RTS) ? (w + 16'd1) : w;
               step_in = c6502_pkg::Q_FETCH;
               acc_list[0] = '{addr: pc_in, we: 1'b0, wd: 8'h00};
               acc_count = 3'd1;
            end
            default: ;
         endcase
         // memory phase shared by the zero page, absolute and indirect data addressing modes
         if (isst) begin
            if (dcur.kind == c6502_pkg::K_STA || dcur.kind == c6502_pkg::K_STX ||
                dcur.kind == c6502_pkg::K_STY) begin
               stv = (dcur.kind == c6502_pkg::K_STA) ? a_ff :
                     (dcur.kind == c6502_pkg::K_STX) ? x_ff : y_ff;
               acc_list[0] = '{addr: ea_in, we: 1'b1, wd: stv};
               acc_list[1] = '{addr: pc_in, we: 1'b0, wd: 8'h00};
               acc_count = 3'd2;
               step_in = c6502_pkg::Q_FETCH;
            end else begin
               acc_list[0] = '{addr: ea_in, we: 1'b0, wd: 8'h00};
               acc_count = 3'd1;
               step_in = c6502_pkg::Q_DATA;
            end
         end
      end
      stat = stop_in;
      flags = p_in & c6502_pkg::KEEP_FLAGS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
         a_ff <= '0;
         x_ff <= '0;
         y_ff <= '0;
         sp_ff <= '0;
         p_ff <= '0;
         op_ff <= '0;
         step_ff <= c6502_pkg::Q_IDLE;
         ow_ff <= '0;
         ea_ff <= '0;
         stop_ff <= '0;
      end else if (go) begin
         pc_ff <= pc_in;
         a_ff <= a_in;
         x_ff <= x_in;
         y_ff <= y_in;
         sp_ff <= sp_in;
         p_ff <= p_in;
         op_ff <= op_in;
         step_ff <= step_in;
         ow_ff <= ow_in;
         ea_ff <= ea_in;
         stop_ff <= stop_in;
      end
   end

endmodule

>>> rtl/c6502_outq.sv
// result queue: holds up to four bus accesses of one transaction; pops one a cycle on rsp_ready
module c6502_outq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  c6502_pkg::acc_type    acc_list [4],
   input  logic [2:0]            acc_count,
   input  logic [1:0]            stat,
   input  logic [7:0]            flags,
   output logic                  empty_next,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output c6502_pkg::rsp_type    rsp_payload
);

   c6502_pkg::acc_type ent_ff [4];
   logic [2:0] cnt_ff, cnt_in;
   logic [1:0] rd_ff, rd_in;
   logic [1:0] st_ff;
   logic [7:0] fl_ff;
   logic       pop;

   assign rsp_valid = (cnt_ff != 3'd0);
   assign pop = rsp_valid && rsp_ready;
   assign empty_next = (cnt_ff == 3'd0) || (pop && cnt_ff == 3'd1);

   always_comb begin
      cnt_in = cnt_ff;
      rd_in = rd_ff;
      if (load) begin
         cnt_in = acc_count;
         rd_in = 2'd0;
      end else if (pop) begin
         cnt_in = cnt_ff - 3'd1;
         rd_in = rd_ff + 2'd1;
      end
   end

   always_comb begin
      rsp_payload.bus_address = ent_ff[rd_ff].addr;
      rsp_payload.write_enable = ent_ff[rd_ff].we;
      rsp_payload.write_data = ent_ff[rd_ff].wd;
      rsp_payload.run_status = st_ff;
      rsp_payload.flags_out = fl_ff;
      rsp_payload.last = (cnt_ff == 3'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < 4; i++) ent_ff[i] <= acc_list[i];
         st_ff <= stat;
         fl_ff <= flags;
      end
   end

endmodule

>>> tb/sv/cpu_6502_instruction_core_unit_chk.sv
// bus access predictor and response checker for the 6502 core testbench
`timescale 1ns / 1ps
module cpu_6502_instruction_core_unit_chk
   import c6502_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_payload,
   output int      fail_count,
   output int      outstanding
);

   logic [15:0] pc, ea, opw;
   logic [7:0]  acc, ix, iy, sp, psr, opc;
   logic [1:0]  halt_code;
   step_type    seq;
   rsp_type     bus_q[$];
   rsp_type     step_q[$];

   function void bus_access(input logic [15:0] ad, input logic we, input logic [7:0] wd);
      rsp_type r;
      r = '0;
      r.bus_address = ad;
      r.write_enable = we;
      r.write_data = we ? wd : 8'h00;
      if (step_q.size() < 4) step_q.push_back(r);
   endfunction

   function void fetch_next();
      seq = Q_FETCH;
      bus_access(pc, 1'b0, 8'h00);
   endfunction

   function void push_byte(input logic [7:0] v);
      bus_access({STACK_PAGE, sp}, 1'b1, v);
      sp = sp - 8'd1;
   endfunction

   function void pull_byte(input step_type nxt);
      sp = sp + 8'd1;
      seq = nxt;
      bus_access({STACK_PAGE, sp}, 1'b0, 8'h00);
   endfunction

   function void flag(input logic [7:0] mask, input logic on);
      psr = on ? (psr | mask) : (psr & ~mask);
   endfunction

   function logic [7:0] nz(input logic [7:0] v);
      flag(F_N, v[7]);
      flag(F_Z, v == 8'h00);
      return v;
   endfunction

   function kind_type group0(input logic [2:0] a);
      case (a)
         3'd1: return K_BIT;
         3'd4: return K_STY;
         3'd5: return K_LDY;
         3'd6: return K_CPY;
         3'd7: return K_CPX;
         default: return K_ILL;
      endcase
   endfunction

   function dec_type split_opcode(input logic [7:0] op);
      dec_type d;
      logic [2:0] a, b;
      a = op[7:5];
      b = op[4:2];
      d.mode = M_IMP;
      d.kind = K_ILL;
      case (op[1:0])
         2'd1: if (op != OP_STAI) begin
            case (b)
               3'd0: d.mode = M_IZX;
               3'd1: d.mode = M_ZP;
               3'd2: d.mode = M_IMM;
               3'd3: d.mode = M_ABS;
               3'd4: d.mode = M_IZY;
               3'd5: d.mode = M_ZPX;
               3'd6: d.mode = M_ABY;
               default: d.mode = M_ABX;
            endcase
            d.kind = kind_type'(K_ORA + a);
         end
         2'd2: if (op == OP_HLT) begin
            d.kind = K_HALT;
         end else begin
            case (b)
               3'd0: if (op == OP_LDXI) begin
                  d.mode = M_IMM;
                  d.kind = K_LDX;
               end
               3'd1: begin
                  d.mode = M_ZP;
                  d.kind = kind_type'(K_ASL + a);
               end
               3'd2: d.kind = (a < 3'd4) ? kind_type'(K_ASL + a) : K_IMPL;
               3'd3: begin
                  d.mode = M_ABS;
                  d.kind = kind_type'(K_ASL + a);
               end
               3'd5: begin
                  d.mode = (a == 3'd4 || a == 3'd5) ? M_ZPY : M_ZPX;
                  d.kind = kind_type'(K_ASL + a);
               end
               3'd6: if (op == OP_TXS || op == OP_TSX) d.kind = K_IMPL;
               3'd7: if (a != 3'd4) begin
                  d.mode = (a == 3'd5) ? M_ABY : M_ABX;
                  d.kind = kind_type'(K_ASL + a);
               end
               default: ;
            endcase
         end
         2'd0: case (b)
            3'd0: begin
               if (a == 3'd0) d.kind = K_BRK;
               else if (a == 3'd1) begin
                  d.mode = M_ABS;
                  d.kind = K_JSR;
               end else if (a == 3'd2) d.kind = K_RTI;
               else if (a == 3'd3) d.kind = K_RTS;
               else if (a >= 3'd5) begin
                  d.mode = M_IMM;
                  d.kind = group0(a);
               end
            end
            3'd1: begin
               d.mode = M_ZP;
               d.kind = group0(a);
            end
            3'd2, 3'd6: d.kind = K_IMPL;
            3'd3: begin
               d.mode = M_ABS;
               if (a == 3'd2) d.kind = K_JMP;
               else if (a == 3'd3) begin
                  d.mode = M_IND;
                  d.kind = K_JMP;
               end else d.kind = group0(a);
            end
            3'd4: begin
               d.mode = M_REL;
               d.kind = K_BR;
            end
            3'd5: if (a == 3'd4 || a == 3'd5) begin
               d.mode = M_ZPX;
               d.kind = group0(a);
            end
            default: if (a == 3'd5) begin
               d.mode = M_ABX;
               d.kind = K_LDY;
            end
         endcase
         default: ;
      endcase
      return d;
   endfunction

   function void compare_reg(input logic [7:0] r, input logic [7:0] v);
      logic [7:0] t;
      flag(F_C, r >= v);
      t = nz(r - v);
   endfunction

   function void add_carry(input logic [7:0] v);
      int a, c, bsum, lo, s;
      a = acc;
      c = psr[0];
      bsum = a + v + c;
      if (psr & F_D) begin
         lo = (a & 15) + (v & 15) + c;
         if (lo >= 10) lo = ((lo + 6) & 15) + 16;
         s = (a & 240) + (v & 240) + lo;
         flag(F_V, ((~(a ^ v)) & (a ^ s) & 128) != 0);
         flag(F_N, (s & 128) != 0);
         flag(F_Z, (bsum & 255) == 0);
         if (s >= 160) s += 96;
         flag(F_C, s >= 256);
         acc = s[7:0];
      end else begin
         flag(F_V, ((~(a ^ v)) & (a ^ bsum) & 128) != 0);
         flag(F_C, bsum > 255);
         acc = nz(bsum[7:0]);
      end
   endfunction

   function void sub_borrow(input logic [7:0] v);
      int a, c, nv, bsum, lo, r;
      logic [7:0] t;
      a = acc;
      c = psr[0];
      nv = v ^ 8'hFF;
      bsum = a + nv + c;
      flag(F_V, ((~(a ^ nv)) & (a ^ bsum) & 128) != 0);
      flag(F_C, bsum > 255);
      t = nz(bsum[7:0]);
      if (psr & F_D) begin
         lo = (a & 15) - (v & 15) + c - 1;
         if (lo < 0) lo = ((lo + 26) & 15) - 16;
         r = (a & 240) - (v & 240) + lo;
         if (r < 0) r -= 96;
         r = (r + 512) & 255;
         acc = r[7:0];
      end else begin
         acc = bsum[7:0];
      end
   endfunction

   function logic [7:0] shift_rmw(input kind_type k, input logic [7:0] v);
      logic oldc;
      logic [7:0] r;
      oldc = psr[0];
      case (k)
         K_ASL: begin r = {v[6:0], 1'b0}; flag(F_C, v[7]); end
         K_ROL: begin r = {v[6:0], oldc}; flag(F_C, v[7]); end
         K_LSR: begin r = {1'b0, v[7:1]}; flag(F_C, v[0]); end
         K_ROR: begin r = {oldc, v[7:1]}; flag(F_C, v[0]); end
         K_DEC: r = v - 8'd1;
         default: r = v + 8'd1;
      endcase
      return nz(r);
   endfunction

   function logic apply_operand(input kind_type k, input logic [7:0] v, output logic [7:0] wb);
      wb = 8'h00;
      case (k)
         K_ORA: acc = nz(acc | v);
         K_AND: acc = nz(acc & v);
         K_EOR: acc = nz(acc ^ v);
         K_ADC: add_carry(v);
         K_SBC: sub_borrow(v);
         K_LDA: acc = nz(v);
         K_LDX: ix = nz(v);
         K_LDY: iy = nz(v);
         K_CMP: compare_reg(acc, v);
         K_CPX: compare_reg(ix, v);
         K_CPY: compare_reg(iy, v);
         K_BIT: begin
            psr = (psr & ~NV_BITS) | (v & NV_BITS);
            flag(F_Z, (acc & v) == 8'h00);
         end
         K_ASL, K_ROL, K_LSR, K_ROR, K_DEC, K_INC: begin
            wb = shift_rmw(k, v);
            return 1'b1;
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   function void memory_access(input kind_type k);
      if (k == K_STA || k == K_STX || k == K_STY) begin
         bus_access(ea, 1'b1, (k == K_STA) ? acc : (k == K_STX) ? ix : iy);
         fetch_next();
      end else begin
         seq = Q_DATA;
         bus_access(ea, 1'b0, 8'h00);
      end
   endfunction

   function void run_implied(input kind_type k);
      if (k >= K_ASL && k <= K_ROR) begin
         acc = shift_rmw(k, acc);
      end else if (k == K_BRK) begin
         pc = pc + 16'd1;
         push_byte(pc[15:8]);
         push_byte(pc[7:0]);
         push_byte(psr | PUSH_MARK);
         psr = psr | F_I;
         ea = VEC_BRK;
         seq = Q_VEC_LO;
         bus_access(VEC_BRK, 1'b0, 8'h00);
         return;
      end else if (k == K_RTI) begin
         pull_byte(Q_PULL1);
         return;
      end else if (k == K_RTS) begin
         pull_byte(Q_PULL_LO);
         return;
      end else begin
         case (opc)
            OP_PHP: push_byte(psr | PUSH_MARK);
            OP_PHA: push_byte(acc);
            OP_PLP, OP_PLA: begin
               pull_byte(Q_PULL1);
               return;
            end
            OP_DEY: iy = nz(iy - 8'd1);
            OP_TAY: iy = nz(acc);
            OP_INY: iy = nz(iy + 8'd1);
            OP_INX: ix = nz(ix + 8'd1);
            OP_CLC: flag(F_C, 1'b0);
            OP_SEC: flag(F_C, 1'b1);
            OP_CLI: flag(F_I, 1'b0);
            OP_SEI: flag(F_I, 1'b1);
            OP_TYA: acc = nz(iy);
            OP_CLV: flag(F_V, 1'b0);
            OP_CLD: flag(F_D, 1'b0);
            OP_SED: flag(F_D, 1'b1);
            OP_TXA: acc = nz(ix);
            OP_TAX: ix = nz(acc);
            OP_DEX: ix = nz(ix - 8'd1);
            OP_TXS: sp = ix;
            OP_TSX: ix = nz(sp);
            default: ;
         endcase
      end
      fetch_next();
   endfunction

   function void take_byte(input logic [7:0] d);
      dec_type dc;
      logic [7:0] wb;
      logic [15:0] w;
      logic [7:0] sel_flag;
      dc = split_opcode(opc);
      case (seq)
         Q_VEC_LO: begin
            opw = {8'h00, d};
            seq = Q_VEC_HI;
            bus_access(ea + 16'd1, 1'b0, 8'h00);
         end
         Q_VEC_HI: begin
            pc = {d, opw[7:0]};
            fetch_next();
         end
         Q_FETCH: begin
            opc = d;
            dc = split_opcode(d);
            if (dc.kind == K_HALT || dc.kind == K_ILL) begin
               halt_code = (dc.kind == K_HALT) ? RUN_HALT : RUN_ILL;
               seq = Q_STOP;
               bus_access(pc, 1'b0, 8'h00);
            end else begin
               pc = pc + 16'd1;
               if (dc.mode == M_IMP) run_implied(dc.kind);
               else begin
                  seq = Q_OP1;
                  bus_access(pc, 1'b0, 8'h00);
               end
            end
         end
         Q_OP1: begin
            opw = {8'h00, d};
            pc = pc + 16'd1;
            case (dc.mode)
               M_IMM: begin
                  void'(apply_operand(dc.kind, d, wb));
                  fetch_next();
               end
               M_REL: begin
                  case (opc[7:6])
                     2'd0: sel_flag = F_N;
                     2'd1: sel_flag = F_V;
                     2'd2: sel_flag = F_C;
                     default: sel_flag = F_Z;
                  endcase
                  if (((psr & sel_flag) != 8'h00) == opc[5]) pc = pc + {{8{d[7]}}, d};
                  fetch_next();
               end
               M_ZP: begin ea = {8'h00, d}; memory_access(dc.kind); end
               M_ZPX: begin ea = {8'h00, d + ix}; memory_access(dc.kind); end
               M_ZPY: begin ea = {8'h00, d + iy}; memory_access(dc.kind); end
               M_IZX, M_IZY: begin
                  ea = (dc.mode == M_IZX) ? {8'h00, d + ix} : {8'h00, d};
                  seq = Q_PTR_LO;
                  bus_access(ea, 1'b0, 8'h00);
               end
               default: begin
                  seq = Q_OP2;
                  bus_access(pc, 1'b0, 8'h00);
               end
            endcase
         end
         Q_OP2: begin
            w = {d, opw[7:0]};
            opw = w;
            pc = pc + 16'd1;
            if (dc.kind == K_JMP && dc.mode == M_IND) begin
               ea = w;
               seq = Q_PTR_LO;
               bus_access(w, 1'b0, 8'h00);
            end else if (dc.kind == K_JMP) begin
               pc = w;
               fetch_next();
            end else if (dc.kind == K_JSR) begin
               push_byte(8'((pc - 16'd1) >> 8));
               push_byte(8'(pc - 16'd1));
               pc = w;
               fetch_next();
            end else begin
               if (dc.mode == M_ABX) ea = w + ix;
               else if (dc.mode == M_ABY) ea = w + iy;
               else ea = w;
               memory_access(dc.kind);
            end
         end
         Q_PTR_LO: begin
            opw = {8'h00, d};
            seq = Q_PTR_HI;
            if (dc.mode == M_IND) bus_access({ea[15:8], ea[7:0] + 8'd1}, 1'b0, 8'h00);
            else bus_access({8'h00, ea[7:0] + 8'd1}, 1'b0, 8'h00);
         end
         Q_PTR_HI: begin
            w = {d, opw[7:0]};
            if (dc.mode == M_IND) begin
               pc = w;
               fetch_next();
            end else begin
               ea = (dc.mode == M_IZY) ? w + iy : w;
               memory_access(dc.kind);
            end
         end
         Q_DATA: begin
            if (apply_operand(dc.kind, d, wb)) bus_access(ea, 1'b1, wb);
            fetch_next();
         end
         Q_PULL1: begin
            if (opc == OP_PLA) begin
               acc = nz(d);
               fetch_next();
            end else begin
               psr = d & KEEP_FLAGS;
               if (opc == OP_RTI) pull_byte(Q_PULL_LO);
               else fetch_next();
            end
         end
         Q_PULL_LO: begin
            opw = {8'h00, d};
            pull_byte(Q_PULL_HI);
         end
         Q_PULL_HI: begin
            pc = {d, opw[7:0]};
            if (opc == OP_RTS) pc = pc + 16'd1;
            fetch_next();
         end
         default: ;
      endcase
   endfunction

   function void predict_transaction(input req_type t);
      step_q.delete();
      if (t.command == 1'b0) begin
         sp = 8'hFF;
         psr = psr | F_I;
         halt_code = RUN_OK;
         ea = VEC_RESET;
         seq = Q_VEC_LO;
         bus_access(VEC_RESET, 1'b0, 8'h00);
      end else begin
         take_byte(t.read_data);
      end
      foreach (step_q[i]) begin
         step_q[i].run_status = halt_code;
         step_q[i].flags_out = psr & KEEP_FLAGS;
         step_q[i].last = (i == step_q.size() - 1);
         bus_q.push_back(step_q[i]);
      end
   endfunction

   task report(input string what, input logic [15:0] got, input logic [15:0] want);
      $display("%0t: %s got %h expected %h", $time, what, got, want);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         pc = '0; ea = '0; opw = '0;
         acc = '0; ix = '0; iy = '0; sp = '0; psr = '0; opc = '0;
         halt_code = RUN_OK;
         seq = Q_IDLE;
         bus_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (bus_q.size() == 0) begin
               report("unexpected transaction address", rsp_payload.bus_address, 16'h0);
            end else begin
               e = bus_q.pop_front();
               if (rsp_payload.bus_address !== e.bus_address)
                  report("bus_address", rsp_payload.bus_address, e.bus_address);
               if (rsp_payload.write_enable !== e.write_enable)
                  report("write_enable", rsp_payload.write_enable, e.write_enable);
               if (rsp_payload.write_data !== e.write_data)
                  report("write_data", rsp_payload.write_data, e.write_data);
               if (rsp_payload.run_status !== e.run_status)
                  report("run_status", rsp_payload.run_status, e.run_status);
               if (rsp_payload.flags_out !== e.flags_out)
                  report("flags_out", rsp_payload.flags_out, e.flags_out);
               if (rsp_payload.last !== e.last)
                  report("last", rsp_payload.last, e.last);
            end
         end
         if (req_valid && req_ready) predict_transaction(req_payload);
      end
      outstanding = bus_q.size();
   end

endmodule

>>> tb/sv/cpu_6502_instruction_core_unit_tb.sv
// top of the 6502 core testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module cpu_6502_instruction_core_unit_tb;
   import c6502_pkg::*;

   localparam logic       CMD_START = 1'b0;
   localparam logic       CMD_DATA = 1'b1;
   localparam logic [7:0] OP_BRK = 8'h00;
   localparam logic [7:0] OP_LDA_IMM = 8'hA9;
   localparam logic [7:0] OP_ADC_IMM = 8'h69;
   localparam logic [7:0] OP_SBC_IMM = 8'hE9;
   localparam logic [7:0] OP_JMP_IND = 8'h6C;
   localparam int STALL_LIMIT = 2000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;
   int      fail_count;
   int      outstanding;
   logic    calm = 1'b0;
   logic    hold_go = 1'b0;
   logic    stopped = 1'b0;
   int      stall = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   cpu_6502_instruction_core_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   cpu_6502_instruction_core_unit_chk checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .fail_count(fail_count), .outstanding(outstanding)
   );

   // a start clears the stop mark, a stopped status response sets it
   always @(posedge clock) begin
      if (reset) stopped <= 1'b0;
      else if (req_valid && req_ready && req_payload.command == CMD_START) stopped <= 1'b0;
      else if (rsp_valid && rsp_ready && rsp_payload.run_status != RUN_OK) stopped <= 1'b1;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall <= 0;
         else stall <= stall + 1;
         if (stall == STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // response side: random back pressure, one long hold-off on request
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_go) begin
            hold_go = 1'b0;
            rsp_ready <= 1'b0;
            repeat (60) @(negedge clock);
         end
         rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 10);
      end
   end

   task send(input logic cmd, input logic [7:0] d);
      if (!calm) begin
         while ($urandom_range(99) < 10) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_payload <= '{command: cmd, read_data: d};
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      logic [7:0] prog[$];
      logic [7:0] b;
      int n;
      prog = '{8'h00, 8'h02, OP_LDA_IMM, 8'h99, OP_SED, OP_ADC_IMM, 8'h01, OP_SEC,
               OP_SBC_IMM, 8'h00, OP_BRK, 8'h00, 8'h03, OP_PHA, OP_PLP, 8'hFF,
               OP_JMP_IND, 8'hFF, 8'h12, 8'h34, 8'h05, OP_HLT};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send(CMD_START, 8'h00);
      foreach (prog[i]) send(CMD_DATA, prog[i]);
      send(CMD_START, 8'hFF);
      n = 0;
      while (n < 76) begin
         calm = (n >= 25 && n < 45);
         if (n == 50) hold_go = 1'b1;
         if (n == 62) begin
            req_valid <= 1'b0;
            do @(negedge clock); while (outstanding != 0);
         end
         if (stopped || $urandom_range(99) < 2) begin
            send(CMD_START, 8'($urandom));
         end else begin
            b = 8'($urandom);
            if ($urandom_range(99) < 45) b[1:0] = 2'b01;
            send(CMD_DATA, b);
         end
         n++;
      end
      req_valid <= 1'b0;
      calm = 1'b1;
      while (outstanding != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
